[hdl/tcpe_pkg.sv]
// tcpe_pkg: shared types and constants of the tof cluster position estimator
// no dependencies; used by hdl/tof_cluster_position_estimator.sv
`default_nettype none

package tcpe_pkg;

	// field widths of the input and result words
	localparam int SIDE_W = 2;
	localparam int TIME_W = 24;
	localparam int HGT_W  = 16;
	localparam int XPOS_W = 16;
	localparam int ID_W   = 16;
	localparam int Y_W    = 16;
	localparam int RES_W  = 12;
	localparam int HSUM_W = 21;
	localparam int XC_W   = 13;
	localparam int XK_W   = 12;
	localparam int TSUM_W = 28;

	localparam int S_DATA_W = 88;
	localparam int M_DATA_W = 80;

	// hit side codes
	localparam logic [SIDE_W-1:0] SIDE_LEFT  = 2'd1;
	localparam logic [SIDE_W-1:0] SIDE_RIGHT = 2'd2;

	// y = dt_ps * KNUM / KDEN in 1/16 mm
	localparam int KNUM_W = 39;
	localparam int KDEN_W = 37;
	localparam logic [KNUM_W-1:0] KNUM = 39'd378937666912;
	localparam logic [KDEN_W-1:0] KDEN = 37'd100000000000;

	// time difference cap, 9000 ps per unit of nl*nr
	localparam int CAP_W = 14;
	localparam logic [CAP_W-1:0] CAP_MUL = 14'd9000;

	// quotient bits of the position division
	localparam int QB = 16;

	localparam logic signed [17:0] BAR_HALF = 18'sd3160;
	localparam logic signed [17:0] Y_MAX    = 18'sd32767;
	localparam logic signed [17:0] Y_MIN    = -18'sd32768;

	localparam logic [RES_W-1:0]  RES_BOTH = 12'd2274;
	localparam logic [RES_W-1:0]  RES_ONE  = 12'd1824;
	localparam logic [HSUM_W-1:0] HSUM_MAX = 21'h1FFFFF;

	localparam logic [TSUM_W-1:0] TSUM_MAX = 28'h7FFFFFF;
	localparam logic [TSUM_W-1:0] TSUM_MIN = 28'h8000000;

	// x bin: floor(|x| / 800) = ((|x| >> 5) * 5243) >> 17
	localparam logic [12:0] XBIN_RECIP = 13'd5243;
	localparam int          XBIN_SHIFT = 17;
	localparam logic [5:0]  XBIN_MM    = 6'd50;
	localparam logic [XK_W-1:0] XBIN_HALF = 12'd25;

	typedef enum logic [2:0] {
		S_IDLE,
		S_NUM_L,
		S_NUM_R,
		S_ABS,
		S_MULK,
		S_DIV,
		S_RND,
		S_FIN
	} seq_state_t;

endpackage

`default_nettype wire

[hdl/tof_cluster_position_estimator.sv]
// tof_cluster_position_estimator: top level, hit accumulation and position sequencer
// depends on hdl/tcpe_pkg.sv
//
//  channel | direction | handshake              | word
//  --------+-----------+------------------------+-------------------------------------------
//  s_      | in        | s_tvalid / s_tready    | one hit; tlast ends the cluster
//  m_      | out       | m_tvalid / m_tready    | one cluster result
//  cfg_    | in        | cfg_valid / cfg_ready  | force_into_bar bit
//
// a hit that is not last is accepted and the next hit may follow at once
// a last hit with only one end seen goes from accept straight to the result load in S_FIN
// a last hit with both ends steps through S_NUM_L, S_NUM_R, S_ABS, S_MULK, S_DIV, S_RND and S_FIN;
// the 65-bit shared adder does the numerator, the constant product and the division
// s_tready is low while a cluster result is computed or while it waits for the output
// register; the output register lets new hits in while a result waits on m_tready
// reset clears all sums, counts and the output valid; no clearing pass is needed
`default_nettype none

module tof_cluster_position_estimator #(
	parameter int MAX_HITS = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,

	input  wire logic        s_tvalid,
	output logic             s_tready,
	// [23:0] start_time, [39:24] signal_height, [55:40] x_position,
	// [71:56] detector_id, [87:72] channel_number
	input  wire logic [tcpe_pkg::S_DATA_W-1:0] s_tdata,
	// [1:0] hit_side
	input  wire logic [tcpe_pkg::SIDE_W-1:0]   s_tuser,
	input  wire logic        s_tlast,

	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [15:0] y_estimate, [27:16] y_resolution, [48:28] signal_sum,
	// [64:49] cluster_det_id, [77:65] x_center, [79:78] zero
	output logic [tcpe_pkg::M_DATA_W-1:0] m_tdata,
	// [0] both_ends_seen
	output logic [0:0]       m_tuser,

	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_data
);

	// counter widths follow from the hit limit
	localparam int CNT_W  = $clog2(MAX_HITS + 1);
	localparam int DEN_W  = 2 * CNT_W;
	localparam int MAG_W  = DEN_W + tcpe_pkg::CAP_W;
	localparam int N_W    = MAG_W + tcpe_pkg::KNUM_W;
	localparam int D_W    = DEN_W + tcpe_pkg::KDEN_W;
	localparam int STEP_W = $clog2(MAG_W + 1);
	localparam int TS_W   = tcpe_pkg::TSUM_W;

	// input fields
	logic [tcpe_pkg::SIDE_W-1:0] hit_side;
	logic signed [tcpe_pkg::TIME_W-1:0] start_time;
	logic [tcpe_pkg::HGT_W-1:0]  signal_height;
	logic signed [tcpe_pkg::XPOS_W-1:0] x_position;
	logic [tcpe_pkg::ID_W-1:0]   detector_id;
	logic [tcpe_pkg::ID_W-1:0]   channel_number;
	logic                        last_hit;

	assign hit_side       = s_tuser;
	assign start_time     = s_tdata[23:0];
	assign signal_height  = s_tdata[39:24];
	assign x_position     = s_tdata[55:40];
	assign detector_id    = s_tdata[71:56];
	assign channel_number = s_tdata[87:72];
	assign last_hit       = s_tlast;

	// cluster accumulators
	logic signed [TS_W-1:0] lsum_q, rsum_q, lsum_d, rsum_d;
	logic [CNT_W-1:0] lcnt_q, rcnt_q, lcnt_d, rcnt_d;
	logic [tcpe_pkg::HSUM_W-1:0] hsum_q, hsum_d;
	logic first_q;
	logic signed [tcpe_pkg::XK_W-1:0] xc_q, xc_d;
	logic [tcpe_pkg::ID_W-1:0] det_q;
	logic both_q, both_d;
	logic force_q;

	// sequencer and shared unit
	tcpe_pkg::seq_state_t state_q, state_d;
	logic [STEP_W-1:0] cnt_q;
	logic [N_W-1:0] acc_q, opd_q;
	logic [MAG_W-1:0] mbits_q;
	logic [DEN_W-1:0] den_q;
	logic [D_W-1:0] d_q;
	logic [tcpe_pkg::QB:0] q_q;
	logic neg_q;

	logic [N_W-1:0] alu_a, alu_b;
	logic           alu_sub;
	logic [N_W:0]   alu_res;

	logic in_acc, out_free, out_load;

	assign in_acc    = s_tvalid && s_tready;
	assign s_tready  = (state_q == tcpe_pkg::S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_free  = !m_tvalid || m_tready;
	assign out_load  = (state_q == tcpe_pkg::S_FIN) && out_free;

	// ---------------- hit accumulation ----------------

	logic signed [TS_W:0] tl_ext, tr_ext;
	logic [tcpe_pkg::HSUM_W:0] hsum_ext;
	logic [tcpe_pkg::XPOS_W:0] x_abs;
	logic [11:0] x_v;
	logic [24:0] x_prod;
	logic [7:0]  x_bin;
	logic [tcpe_pkg::XK_W-1:0] x_c;

	always_comb begin
		lsum_d = lsum_q;
		rsum_d = rsum_q;
		lcnt_d = lcnt_q;
		rcnt_d = rcnt_q;

		// saturating time sums, one end at a time
		tl_ext = {lsum_q[TS_W-1], lsum_q}
			+ {{(TS_W + 1 - tcpe_pkg::TIME_W){start_time[tcpe_pkg::TIME_W-1]}}, start_time};
		tr_ext = {rsum_q[TS_W-1], rsum_q}
			+ {{(TS_W + 1 - tcpe_pkg::TIME_W){start_time[tcpe_pkg::TIME_W-1]}}, start_time};

		if (hit_side == tcpe_pkg::SIDE_LEFT && lcnt_q < CNT_W'(MAX_HITS)) begin
			if (tl_ext[TS_W] != tl_ext[TS_W-1])
				lsum_d = tl_ext[TS_W] ? tcpe_pkg::TSUM_MIN : tcpe_pkg::TSUM_MAX;
			else
				lsum_d = tl_ext[TS_W-1:0];
			lcnt_d = lcnt_q + CNT_W'(1);
		end else if (hit_side == tcpe_pkg::SIDE_RIGHT && rcnt_q < CNT_W'(MAX_HITS)) begin
			if (tr_ext[TS_W] != tr_ext[TS_W-1])
				rsum_d = tr_ext[TS_W] ? tcpe_pkg::TSUM_MIN : tcpe_pkg::TSUM_MAX;
			else
				rsum_d = tr_ext[TS_W-1:0];
			rcnt_d = rcnt_q + CNT_W'(1);
		end

		// saturating height sum
		hsum_ext = {1'b0, hsum_q} + (tcpe_pkg::HSUM_W + 1)'(signal_height);
		hsum_d   = hsum_ext[tcpe_pkg::HSUM_W] ? tcpe_pkg::HSUM_MAX
			: hsum_ext[tcpe_pkg::HSUM_W-1:0];

		both_d = (lcnt_d != '0) && (rcnt_d != '0);

		// x bin centre: 50 * trunc(x_mm / 50) +- 25, sign of x
		x_abs  = x_position[tcpe_pkg::XPOS_W-1]
			? -{x_position[tcpe_pkg::XPOS_W-1], x_position}
			: {1'b0, x_position};
		x_v    = x_abs[16:5];
		x_prod = 25'(x_v) * 25'(tcpe_pkg::XBIN_RECIP);
		x_bin  = x_prod[24:tcpe_pkg::XBIN_SHIFT];
		x_c    = tcpe_pkg::XK_W'(x_bin) * tcpe_pkg::XK_W'(tcpe_pkg::XBIN_MM)
			+ tcpe_pkg::XBIN_HALF;
		xc_d   = x_position[tcpe_pkg::XPOS_W-1] ? -x_c : x_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lsum_q  <= '0;
			rsum_q  <= '0;
			lcnt_q  <= '0;
			rcnt_q  <= '0;
			hsum_q  <= '0;
			first_q <= 1'b1;
			xc_q    <= '0;
			det_q   <= '0;
			both_q  <= 1'b0;
			force_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready)
				force_q <= cfg_data;
			if (in_acc) begin
				lsum_q <= lsum_d;
				rsum_q <= rsum_d;
				lcnt_q <= lcnt_d;
				rcnt_q <= rcnt_d;
				hsum_q <= hsum_d;
				both_q <= both_d;
				if (first_q) begin
					xc_q    <= xc_d;
					det_q   <= detector_id - channel_number;
					first_q <= 1'b0;
				end
			end else if (out_load) begin
				// cluster done, sums, counts and first-hit fields back to reset values
				lsum_q  <= '0;
				rsum_q  <= '0;
				lcnt_q  <= '0;
				rcnt_q  <= '0;
				hsum_q  <= '0;
				first_q <= 1'b1;
				xc_q    <= '0;
				det_q   <= '0;
			end
		end
	end

	// ---------------- shared add / subtract unit ----------------

	always_comb begin
		alu_a   = acc_q;
		alu_b   = opd_q;
		alu_sub = 1'b0;
		case (state_q)
			tcpe_pkg::S_NUM_R: alu_sub = 1'b1;
			tcpe_pkg::S_DIV:   alu_sub = 1'b1;
			tcpe_pkg::S_RND: begin
				// 2 * remainder against the divisor
				alu_a   = {acc_q[N_W-2:0], 1'b0};
				alu_b   = N_W'(d_q);
				alu_sub = 1'b1;
			end
			default: alu_sub = 1'b0;
		endcase
	end

	// carry out of a subtract means a >= b
	assign alu_res = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
		+ (N_W + 1)'(alu_sub);

	// ---------------- sequencer ----------------

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= tcpe_pkg::S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			tcpe_pkg::S_IDLE:
				if (in_acc && last_hit)
					state_d = both_d ? tcpe_pkg::S_NUM_L : tcpe_pkg::S_FIN;
			tcpe_pkg::S_NUM_L:
				if (cnt_q == STEP_W'(CNT_W - 1))
					state_d = tcpe_pkg::S_NUM_R;
			tcpe_pkg::S_NUM_R:
				if (cnt_q == STEP_W'(CNT_W - 1))
					state_d = tcpe_pkg::S_ABS;
			tcpe_pkg::S_ABS:
				state_d = tcpe_pkg::S_MULK;
			tcpe_pkg::S_MULK:
				if (cnt_q == STEP_W'(MAG_W - 1))
					state_d = tcpe_pkg::S_DIV;
			tcpe_pkg::S_DIV:
				if (cnt_q == STEP_W'(tcpe_pkg::QB - 1))
					state_d = tcpe_pkg::S_RND;
			tcpe_pkg::S_RND:
				state_d = tcpe_pkg::S_FIN;
			tcpe_pkg::S_FIN:
				if (out_free)
					state_d = tcpe_pkg::S_IDLE;
			default:
				state_d = tcpe_pkg::S_IDLE;
		endcase
	end

	// ---------------- position datapath ----------------

	logic [N_W-1:0]   acc_abs;
	logic [MAG_W-1:0] cap, mag_sel;

	always_comb begin
		acc_abs = acc_q[N_W-1] ? (~acc_q + N_W'(1)) : acc_q;
		cap     = MAG_W'(den_q) * MAG_W'(tcpe_pkg::CAP_MUL);
		mag_sel = (acc_abs > N_W'(cap)) ? cap : acc_abs[MAG_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else begin
			case (state_q)
				tcpe_pkg::S_NUM_L, tcpe_pkg::S_NUM_R, tcpe_pkg::S_MULK, tcpe_pkg::S_DIV:
					if (state_d != state_q)
						cnt_q <= '0;
					else
						cnt_q <= cnt_q + STEP_W'(1);
				default:
					cnt_q <= '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			tcpe_pkg::S_IDLE:
				// numerator starts with sum_left * n_right
				if (in_acc && last_hit && both_d) begin
					acc_q   <= '0;
					opd_q   <= {{(N_W - TS_W){lsum_d[TS_W-1]}}, lsum_d};
					mbits_q <= MAG_W'(rcnt_d);
				end
			tcpe_pkg::S_NUM_L, tcpe_pkg::S_NUM_R: begin
				if (mbits_q[0])
					acc_q <= alu_res[N_W-1:0];
				den_q <= DEN_W'(lcnt_q) * DEN_W'(rcnt_q);
				if (state_q == tcpe_pkg::S_NUM_L && cnt_q == STEP_W'(CNT_W - 1)) begin
					// then minus sum_right * n_left
					opd_q   <= {{(N_W - TS_W){rsum_q[TS_W-1]}}, rsum_q};
					mbits_q <= MAG_W'(lcnt_q);
				end else begin
					opd_q   <= {opd_q[N_W-2:0], 1'b0};
					mbits_q <= {1'b0, mbits_q[MAG_W-1:1]};
				end
			end
			tcpe_pkg::S_ABS: begin
				neg_q   <= acc_q[N_W-1];
				mbits_q <= mag_sel;
				opd_q   <= N_W'(tcpe_pkg::KNUM);
				acc_q   <= '0;
				d_q     <= D_W'(den_q) * D_W'(tcpe_pkg::KDEN);
			end
			tcpe_pkg::S_MULK: begin
				if (mbits_q[0])
					acc_q <= alu_res[N_W-1:0];
				mbits_q <= {1'b0, mbits_q[MAG_W-1:1]};
				if (cnt_q == STEP_W'(MAG_W - 1)) begin
					// divisor aligned to the top quotient bit
					opd_q <= N_W'(d_q) << (tcpe_pkg::QB - 1);
					q_q   <= '0;
				end else
					opd_q <= {opd_q[N_W-2:0], 1'b0};
			end
			tcpe_pkg::S_DIV: begin
				if (alu_res[N_W])
					acc_q <= alu_res[N_W-1:0];
				q_q   <= {q_q[tcpe_pkg::QB-1:0], alu_res[N_W]};
				opd_q <= {1'b0, opd_q[N_W-1:1]};
			end
			tcpe_pkg::S_RND:
				// round half away from zero on the magnitude
				if (alu_res[N_W])
					q_q <= q_q + (tcpe_pkg::QB + 1)'(1);
			default: ;
		endcase
	end

	// ---------------- result and output register ----------------

	logic signed [17:0] y_raw, y_lim;
	logic signed [tcpe_pkg::Y_W-1:0] y_out;

	always_comb begin
		y_raw = neg_q ? -$signed({1'b0, q_q}) : $signed({1'b0, q_q});
		y_lim = y_raw;
		if (force_q) begin
			if (y_raw > tcpe_pkg::BAR_HALF)
				y_lim = tcpe_pkg::BAR_HALF;
			else if (y_raw < -tcpe_pkg::BAR_HALF)
				y_lim = -tcpe_pkg::BAR_HALF;
		end
		if (y_lim > tcpe_pkg::Y_MAX)
			y_lim = tcpe_pkg::Y_MAX;
		else if (y_lim < tcpe_pkg::Y_MIN)
			y_lim = tcpe_pkg::Y_MIN;
		// position needs both ends
		y_out = both_q ? y_lim[tcpe_pkg::Y_W-1:0] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid <= 1'b0;
		else if (out_load)
			m_tvalid <= 1'b1;
		else if (m_tready)
			m_tvalid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata <= {2'b00,
				{xc_q[tcpe_pkg::XK_W-1], xc_q},
				det_q,
				hsum_q,
				(both_q ? tcpe_pkg::RES_BOTH : tcpe_pkg::RES_ONE),
				y_out};
			m_tuser <= both_q;
		end
	end

endmodule

`default_nettype wire
